[rtl/core/bml_pkg.sv]
// Shared constants, types and result records for the 3x3 binary morphology block.
package bml_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int COORD_W = 12;
  localparam int PIX_W   = 8;
  localparam int CODE_W  = 9;
  localparam int CNT_W   = 25;

  localparam int TBL_REGS  = 8;
  localparam int TBL_IDX_W = $clog2(TBL_REGS);
  localparam int TBL_W     = 64;
  localparam int TBL_BIT_W = $clog2(TBL_W);

  localparam logic [COL_W-1:0]  COL_MAX   = COL_W'(MAX_WIDTH - 1);
  localparam logic [ROW_W-1:0]  ROW_MAX   = ROW_W'(MAX_HEIGHT - 1);
  localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(1 << 24);
  localparam logic [CODE_W-1:0] KEEP_MASK = 9'h0DB;
  localparam logic [PIX_W-1:0]  VALUE_ON  = 8'd255;
  localparam logic [PIX_W-1:0]  VALUE_OFF = 8'd0;

  localparam int SLOTS = 3;

  typedef struct packed {
    logic [COORD_W-1:0] out_row;
    logic [COORD_W-1:0] out_col;
    logic [PIX_W-1:0]   out_value;
    logic               changed;
    logic               matched;
    logic [CNT_W-1:0]   changed_total;
    logic               run_last;
    logic               frame_last;
  } res_t;

  typedef struct packed {
    logic [SLOTS-1:0]      mask;
    res_t [SLOTS-1:0]      slot;
  } bundle_t;

endpackage

[rtl/core/bml_ifs.sv]
// Valid/ready stream interfaces for the pixel input and the result output.
interface bml_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel;
  logic       row_end;
  logic       final_row;

  modport source (output valid, output pixel, output row_end, output final_row, input ready);
  modport sink (input valid, input pixel, input row_end, input final_row, output ready);
endinterface

interface bml_res_if;
  logic        valid;
  logic        ready;
  logic [11:0] out_row;
  logic [11:0] out_col;
  logic [7:0]  out_value;
  logic        changed;
  logic        matched;
  logic [24:0] changed_total;
  logic        run_last;
  logic        frame_last;

  modport source (output valid, output out_row, output out_col, output out_value,
                  output changed, output matched, output changed_total,
                  output run_last, output frame_last, input ready);
  modport sink (input valid, input out_row, input out_col, input out_value,
                input changed, input matched, input changed_total,
                input run_last, input frame_last, output ready);
endinterface

[rtl/core/bml_line_mem.sv]
// Two-row line buffer: one 2-bit entry per column with a registered read port.
module bml_line_mem (
  input  logic                      clk,
  input  logic                      we,
  input  logic [bml_pkg::COL_W-1:0] waddr,
  input  logic [1:0]                wdata,
  input  logic [bml_pkg::COL_W-1:0] raddr,
  output logic [1:0]                rdata
);
  import bml_pkg::*;

  logic [1:0] mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/bml_lut.sv]
// Configurable 512-entry lookup table held in eight 64-bit registers.
module bml_lut (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_en,
  input  logic [bml_pkg::TBL_IDX_W-1:0] cfg_index,
  input  logic [bml_pkg::TBL_W-1:0]     cfg_data,
  input  logic [bml_pkg::CODE_W-1:0]    code,
  output logic                          hit
);
  import bml_pkg::*;

  logic [TBL_W-1:0] table_bits [TBL_REGS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TBL_REGS; i++) begin
        table_bits[i] <= '0;
      end
    end else if (cfg_en) begin
      table_bits[cfg_index] <= cfg_data;
    end
  end

  assign hit = table_bits[code[CODE_W-1:TBL_BIT_W]][code[TBL_BIT_W-1:0]];

endmodule

[rtl/core/bml_window.sv]
// Window, coordinate and change counters; builds the results of one accepted pixel.
module bml_window (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  logic                       pix_bit,
  input  logic                       row_end,
  input  logic                       final_row,
  input  logic [1:0]                 line_rd,
  input  logic                       hit,
  output logic [bml_pkg::CODE_W-1:0] code,
  output logic                       line_we,
  output logic [bml_pkg::COL_W-1:0]  line_waddr,
  output logic [1:0]                 line_wdata,
  output logic [bml_pkg::COL_W-1:0]  line_raddr,
  output bml_pkg::bundle_t           bundle
);
  import bml_pkg::*;

  logic [CODE_W-1:0] window_bits;
  logic [ROW_W-1:0]  row_count;
  logic [COL_W-1:0]  col_count;
  logic [CNT_W-1:0]  changed_count;

  logic [CODE_W-1:0] window_next;
  logic [ROW_W-1:0]  row_count_next;
  logic [COL_W-1:0]  col_count_next;
  logic [CNT_W-1:0]  changed_count_next;
  logic [CNT_W-1:0]  cnt_new;
  logic              top;
  logic              mid;
  logic              interior;
  logic              chg;
  logic              mat;
  logic              frame_end;
  logic [ROW_W-1:0]  row_prev;
  logic [COL_W-1:0]  col_prev;

  assign top = line_rd[1];
  assign mid = line_rd[0];

  assign window_next = ((window_bits >> 1) & KEEP_MASK) | (CODE_W'(top) << 2)
                     | (CODE_W'(mid) << 5) | (CODE_W'(pix_bit) << 8);
  assign code = window_next;

  assign interior = (row_count >= ROW_W'(2)) && (col_count >= COL_W'(2));
  assign chg      = interior && (hit != window_next[4]);
  assign mat      = interior && hit;
  assign cnt_new  = (chg && (changed_count < CNT_MAX)) ? changed_count + CNT_W'(1)
                                                       : changed_count;
  assign frame_end = final_row && row_end;
  assign row_prev  = row_count - ROW_W'(1);
  assign col_prev  = col_count - COL_W'(1);

  always_comb begin
    bundle.mask[0] = (row_count != '0) && (col_count != '0);
    bundle.mask[1] = (row_count != '0) && row_end;
    bundle.mask[2] = final_row;

    bundle.slot[0].out_row       = COORD_W'(row_prev);
    bundle.slot[0].out_col       = COORD_W'(col_prev);
    bundle.slot[0].out_value     = mat ? VALUE_ON : VALUE_OFF;
    bundle.slot[0].changed       = chg;
    bundle.slot[0].matched       = mat;
    bundle.slot[0].changed_total = cnt_new;
    bundle.slot[0].run_last      = !row_end && !final_row;
    bundle.slot[0].frame_last    = 1'b0;

    bundle.slot[1].out_row       = COORD_W'(row_prev);
    bundle.slot[1].out_col       = COORD_W'(col_count);
    bundle.slot[1].out_value     = VALUE_OFF;
    bundle.slot[1].changed       = 1'b0;
    bundle.slot[1].matched       = 1'b0;
    bundle.slot[1].changed_total = cnt_new;
    bundle.slot[1].run_last      = !final_row;
    bundle.slot[1].frame_last    = 1'b0;

    bundle.slot[2].out_row       = COORD_W'(row_count);
    bundle.slot[2].out_col       = COORD_W'(col_count);
    bundle.slot[2].out_value     = VALUE_OFF;
    bundle.slot[2].changed       = 1'b0;
    bundle.slot[2].matched       = 1'b0;
    bundle.slot[2].changed_total = cnt_new;
    bundle.slot[2].run_last      = 1'b1;
    bundle.slot[2].frame_last    = frame_end;
  end

  always_comb begin
    if (frame_end) begin
      row_count_next     = '0;
      col_count_next     = '0;
      changed_count_next = '0;
    end else if (row_end) begin
      col_count_next     = '0;
      row_count_next     = (row_count == ROW_MAX) ? ROW_MAX : row_count + ROW_W'(1);
      changed_count_next = cnt_new;
    end else begin
      col_count_next     = (col_count == COL_MAX) ? COL_MAX : col_count + COL_W'(1);
      row_count_next     = row_count;
      changed_count_next = cnt_new;
    end
  end

  assign line_we    = accept;
  assign line_waddr = col_count;
  assign line_wdata = {mid, pix_bit};
  assign line_raddr = accept ? col_count_next : col_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_bits   <= '0;
      row_count     <= '0;
      col_count     <= '0;
      changed_count <= '0;
    end else if (accept) begin
      window_bits   <= frame_end ? '0 : window_next;
      row_count     <= row_count_next;
      col_count     <= col_count_next;
      changed_count <= changed_count_next;
    end
  end

endmodule

[rtl/core/bml_out.sv]
// Holds the pending results of one pixel and feeds them through the output register.
module bml_out (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  bml_pkg::bundle_t bundle,
  output logic             free,
  output logic             out_valid,
  input  logic             out_ready,
  output bml_pkg::res_t    out_data
);
  import bml_pkg::*;

  logic [SLOTS-1:0] pend_mask;
  res_t [SLOTS-1:0] pend_slot;

  logic [SLOTS-1:0] pend_mask_next;
  res_t [SLOTS-1:0] pend_slot_next;
  logic [SLOTS-1:0] src_mask;
  res_t [SLOTS-1:0] src_slot;
  res_t             head;
  logic             out_free;
  logic             pend_single;
  logic             move;

  assign out_free    = !out_valid || out_ready;
  assign pend_single = (pend_mask != '0) && ((pend_mask & (pend_mask - SLOTS'(1))) == '0);
  assign free        = (pend_mask == '0) || (pend_single && out_free);

  // The head result comes from the pending set if any remain, else from the new pixel.
  assign src_mask = (pend_mask != '0) ? pend_mask : bundle.mask;
  assign src_slot = (pend_mask != '0) ? pend_slot : bundle.slot;
  assign move     = out_free && ((pend_mask != '0) || (accept && (bundle.mask != '0)));

  always_comb begin
    if (src_mask[0]) begin
      head = src_slot[0];
    end else if (src_mask[1]) begin
      head = src_slot[1];
    end else begin
      head = src_slot[2];
    end
  end

  always_comb begin
    pend_mask_next = pend_mask;
    pend_slot_next = pend_slot;
    if (pend_mask != '0) begin
      if (accept) begin
        pend_mask_next = bundle.mask;
        pend_slot_next = bundle.slot;
      end else if (move) begin
        pend_mask_next = pend_mask & (pend_mask - SLOTS'(1));
      end
    end else if (accept) begin
      pend_slot_next = bundle.slot;
      pend_mask_next = move ? (bundle.mask & (bundle.mask - SLOTS'(1))) : bundle.mask;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_mask <= '0;
      out_valid <= 1'b0;
    end else begin
      pend_mask <= pend_mask_next;
      if (move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_slot <= pend_slot_next;
    if (move) begin
      out_data <= head;
    end
  end

endmodule

[rtl/core/binary_morph_lut_3x3.sv]
// Top level of the streaming 3x3 binary morphology block with a configurable lookup table.
//
// Channel  Dir  Handshake       Word
// pix      in   valid/ready     pixel[7:0] (bit 0 used), row_end, final_row
// res      out  valid/ready     coordinates, value, changed/matched, count, run/frame marks
// cfg      in   write enable    cfg_index selects one of eight 64-bit table registers
//
// A pixel is accepted when the pending results are empty or hold one word that moves to
// the output register in that cycle; its result words reach res through that register.
// Each result beyond the first (row ends, bottom row) needs an output slot of its own, so
// once the one pixel of slack in the pending results is used it holds back pix.ready.
// The line buffer is read ahead at the next column on accept; reset is synchronous.
// A stalled result output backs up into the pending results and then into pix.ready.
module binary_morph_lut_3x3 (
  input  logic                          clk,
  input  logic                          rst,
  bml_pix_if.sink                       pix,
  bml_res_if.source                     res,
  input  logic                          cfg_en,
  input  logic [bml_pkg::TBL_IDX_W-1:0] cfg_index,
  input  logic [bml_pkg::TBL_W-1:0]     cfg_data
);
  import bml_pkg::*;

  logic              accept;
  logic              free;
  logic              hit;
  logic [CODE_W-1:0] code;
  logic              line_we;
  logic [COL_W-1:0]  line_waddr;
  logic [1:0]        line_wdata;
  logic [COL_W-1:0]  line_raddr;
  logic [1:0]        line_rd;
  bundle_t           bundle;
  res_t              out_data;

  assign pix.ready = free && !rst;
  assign accept    = pix.valid && pix.ready;

  bml_line_mem u_line_mem (
    .clk   (clk),
    .we    (line_we),
    .waddr (line_waddr),
    .wdata (line_wdata),
    .raddr (line_raddr),
    .rdata (line_rd)
  );

  bml_lut u_lut (
    .clk       (clk),
    .rst       (rst),
    .cfg_en    (cfg_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .code      (code),
    .hit       (hit)
  );

  bml_window u_window (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .pix_bit    (pix.pixel[0]),
    .row_end    (pix.row_end),
    .final_row  (pix.final_row),
    .line_rd    (line_rd),
    .hit        (hit),
    .code       (code),
    .line_we    (line_we),
    .line_waddr (line_waddr),
    .line_wdata (line_wdata),
    .line_raddr (line_raddr),
    .bundle     (bundle)
  );

  bml_out u_out (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .bundle    (bundle),
    .free      (free),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .out_data  (out_data)
  );

  assign res.out_row       = out_data.out_row;
  assign res.out_col       = out_data.out_col;
  assign res.out_value     = out_data.out_value;
  assign res.changed       = out_data.changed;
  assign res.matched       = out_data.matched;
  assign res.changed_total = out_data.changed_total;
  assign res.run_last      = out_data.run_last;
  assign res.frame_last    = out_data.frame_last;

endmodule
